[sv/keypad_packet_deframer_core_assert.svh]
// assertion macros for the keypad packet deframer
`ifndef KEYPAD_PACKET_DEFRAMER_CORE_ASSERT_SVH
`define KEYPAD_PACKET_DEFRAMER_CORE_ASSERT_SVH

// checked property, disabled while reset is asserted
`define KPD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked property that also holds during reset
`define KPD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[sv/kpd_pkg.sv]
// package with codes and constants of the keypad packet deframer
package kpd_pkg;

    localparam int WIN_DEPTH = 7;
    localparam int CNT_W     = 3;
    localparam int PADDR_W   = 3;

    // register index of the quiz mode register
    localparam logic [0:0] REG_QUIZ_MODE = 1'b0;

    // quiz modes
    localparam logic [2:0] MODE_UNKNOWN  = 3'd0;
    localparam logic [2:0] MODE_RUSH     = 3'd1;
    localparam logic [2:0] MODE_SINGLE   = 3'd2;
    localparam logic [2:0] MODE_MULTIPLE = 3'd3;
    localparam logic [2:0] MODE_NUMBER   = 3'd4;
    localparam logic [2:0] MODE_TEXT     = 3'd5;
    localparam logic [2:0] MODE_HOMEWORK = 3'd6;
    localparam logic [2:0] MODE_USER     = 3'd7;

    // message kinds
    localparam logic [1:0] KIND_TEACHER = 2'd0;
    localparam logic [1:0] KIND_STUDENT = 2'd1;
    localparam logic [1:0] KIND_SET_ID  = 2'd2;
    localparam logic [1:0] KIND_UNCLASS = 2'd3;

    // answer kinds
    localparam logic [2:0] ANS_NONE     = 3'd0;
    localparam logic [2:0] ANS_RUSH     = 3'd1;
    localparam logic [2:0] ANS_CHOICE   = 3'd2;
    localparam logic [2:0] ANS_MASK     = 3'd3;
    localparam logic [2:0] ANS_NUMBER   = 3'd4;
    localparam logic [2:0] ANS_KEY      = 3'd5;
    localparam logic [2:0] ANS_HOMEWORK = 3'd6;

    // top bits of byte 0
    localparam logic [1:0] TOP_KEY    = 2'b00;
    localparam logic [1:0] TOP_HW     = 2'b01;
    localparam logic [1:0] TOP_SET_ID = 2'b10;

    localparam logic [6:0] TEACHER_KEY_LIMIT = 7'd12;
    localparam logic [6:0] SINGLE_RUSH       = 7'd7;
    localparam logic [6:0] SINGLE_LIMIT      = 7'd6;
    localparam logic [6:0] NUMBER_RUSH       = 7'd127;
    localparam logic [6:0] NUMBER_MAX        = 7'd100;

    localparam logic [2:0] LEN_SHORT = 3'd5;
    localparam logic [2:0] LEN_LONG  = 3'd7;

    typedef logic [7:0] byte_t;

endpackage

[sv/keypad_packet_deframer_core.sv]
// keypad packet deframer: byte window, packet check and decode with an output register
//
// One received byte is taken per item and the block accepts an item in every
// unstalled clock cycle, so the sustained rate is one byte per cycle. The byte
// is added to a window of up to seven bytes, the window is checked for a packet
// and the packet is decoded in the same cycle; the result sits in one output
// register and appears in the cycle after the byte that completed the packet.
// While that result is stalled, in_stall is high only if the register cannot
// be emptied in the same cycle. In homework mode a packet is seven bytes whose
// first byte has bits 6..5 equal to 01; in every other mode it is five bytes
// with bit 7 of byte 0 clear and byte 2 equal to the xor of bytes 0, 1, 3 and
// 4. Bytes that do not start a packet are dropped, oldest first, and a decoded
// packet clears the whole window. Some packets (bits 6..5 of 01 or 11 outside
// unknown mode) are consumed without a result. quiz_mode lives at byte address
// 0 of the configuration port and must only be written while the block is idle.
module keypad_packet_deframer_core (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [kpd_pkg::PADDR_W-1:0]    paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    // byte input
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [7:0]                     in_byte,
    // result output
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [1:0]                     msg_kind,
    output logic [8:0]                     keypad_id,
    output logic signed [7:0]              quiz_number,
    output logic [2:0]                     answer_kind,
    output logic [6:0]                     answer_value,
    output logic [23:0]                    answer_codes,
    output logic [55:0]                    packet_bytes,
    output logic [2:0]                     packet_length
);

    // configuration register
    logic [2:0] quiz_mode_reg;
    logic       cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite
                       && (paddr[2] == kpd_pkg::REG_QUIZ_MODE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quiz_mode_reg <= kpd_pkg::MODE_UNKNOWN;
        end
        else if (cfg_write)
        begin
            quiz_mode_reg <= pwdata[2:0];
        end
    end

    always_comb
    begin
        prdata = 32'd0;
        if (paddr[2] == kpd_pkg::REG_QUIZ_MODE)
        begin
            prdata = {29'd0, quiz_mode_reg};
        end
    end

    // handshake: the output register can take a new result when it is empty
    // or being emptied in this cycle
    logic out_valid_reg;
    logic in_accept;

    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;

    // window state
    kpd_pkg::byte_t                 win_reg  [kpd_pkg::WIN_DEPTH];
    kpd_pkg::byte_t                 win_next [kpd_pkg::WIN_DEPTH];
    logic [kpd_pkg::CNT_W-1:0]      count_reg;
    logic [kpd_pkg::CNT_W-1:0]      count_next;

    // window with the new byte appended
    kpd_pkg::byte_t                 app [kpd_pkg::WIN_DEPTH];
    logic [kpd_pkg::CNT_W-1:0]      app_count;

    always_comb
    begin
        for (int i = 0; i < kpd_pkg::WIN_DEPTH; i++)
        begin
            if (count_reg == kpd_pkg::CNT_W'(kpd_pkg::WIN_DEPTH))
            begin
                // full window pushes out its oldest byte first
                if (i < kpd_pkg::WIN_DEPTH - 1)
                begin
                    app[i] = win_reg[i + 1];
                end
                else
                begin
                    app[i] = in_byte;
                end
            end
            else if (count_reg == kpd_pkg::CNT_W'(i))
            begin
                app[i] = in_byte;
            end
            else
            begin
                app[i] = win_reg[i];
            end
        end
        if (count_reg == kpd_pkg::CNT_W'(kpd_pkg::WIN_DEPTH))
        begin
            app_count = count_reg;
        end
        else
        begin
            app_count = count_reg + kpd_pkg::CNT_W'(1);
        end
    end

    // five-byte check at each start offset the window can hold
    logic [2:0] pass;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            pass[k] = (app_count >= kpd_pkg::CNT_W'(k + 5))
                      && !app[k][7]
                      && (app[k + 2] == (app[k] ^ app[k + 1] ^ app[k + 3] ^ app[k + 4]));
        end
    end

    // bytes of the first passing candidate
    kpd_pkg::byte_t b0, b1, b2, b3, b4;

    always_comb
    begin
        if (pass[0])
        begin
            b0 = app[0]; b1 = app[1]; b2 = app[2]; b3 = app[3]; b4 = app[4];
        end
        else if (pass[1])
        begin
            b0 = app[1]; b1 = app[2]; b2 = app[3]; b3 = app[4]; b4 = app[5];
        end
        else
        begin
            b0 = app[2]; b1 = app[3]; b2 = app[4]; b3 = app[5]; b4 = app[6];
        end
    end

    // decode of the current item
    logic              hw_mode;
    logic              hw_full;
    logic              hw_hit;
    logic              five_hit;
    logic [8:0]        kp5;
    logic [6:0]        v5;
    logic [1:0]        top5;
    logic [4:0]        hw_q;
    logic [1:0]        shift;

    logic              res_valid;
    logic [1:0]        res_kind;
    logic [8:0]        res_kp;
    logic [7:0]        res_qn;
    logic [2:0]        res_ak;
    logic [6:0]        res_av;
    logic [23:0]       res_codes;
    logic [55:0]       res_bytes;
    logic [2:0]        res_len;

    assign hw_mode  = (quiz_mode_reg == kpd_pkg::MODE_HOMEWORK);
    assign hw_full  = (app_count == kpd_pkg::CNT_W'(kpd_pkg::WIN_DEPTH));
    assign hw_hit   = hw_mode && hw_full && (app[0][6:5] == kpd_pkg::TOP_HW);
    assign five_hit = !hw_mode && (pass != 3'b000);
    assign kp5      = {b0[4:0], b1[3:0]};
    assign v5       = b4[6:0];
    assign top5     = b0[6:5];
    assign hw_q     = {1'b0, app[0][3:0]} - 5'd1;

    always_comb
    begin
        res_valid = 1'b0;
        res_kind  = kpd_pkg::KIND_STUDENT;
        res_kp    = kp5;
        res_qn    = {1'b0, b3[6:0]};
        res_ak    = kpd_pkg::ANS_NONE;
        res_av    = 7'd0;
        res_codes = 24'd0;
        res_bytes = {16'd0, b0, b1, b2, b3, b4};
        res_len   = kpd_pkg::LEN_SHORT;
        if (hw_hit)
        begin
            res_valid = 1'b1;
            res_kind  = kpd_pkg::KIND_STUDENT;
            res_kp    = {2'b00, app[1][6:0]};
            res_qn    = {hw_q, 3'b001};
            res_ak    = kpd_pkg::ANS_HOMEWORK;
            res_codes = {app[3][6:4], app[3][2:0], app[4][6:4], app[4][2:0],
                         app[5][6:4], app[5][2:0], app[6][6:4], app[6][2:0]};
            res_bytes = {app[0], app[1], app[2], app[3], app[4], app[5], app[6]};
            res_len   = kpd_pkg::LEN_LONG;
        end
        else if (five_hit)
        begin
            if (top5 == kpd_pkg::TOP_KEY && kp5 == 9'd0)
            begin
                // teacher key
                res_valid = 1'b1;
                res_kind  = kpd_pkg::KIND_TEACHER;
                if (v5 < kpd_pkg::TEACHER_KEY_LIMIT)
                begin
                    res_ak = kpd_pkg::ANS_KEY;
                    res_av = v5;
                end
            end
            else if (top5 == kpd_pkg::TOP_KEY)
            begin
                // student answer, read by the quiz mode
                res_valid = 1'b1;
                res_kind  = kpd_pkg::KIND_STUDENT;
                case (quiz_mode_reg)
                    kpd_pkg::MODE_SINGLE:
                    begin
                        if (v5 == kpd_pkg::SINGLE_RUSH)
                        begin
                            res_ak = kpd_pkg::ANS_RUSH;
                        end
                        else if (v5 < kpd_pkg::SINGLE_LIMIT)
                        begin
                            res_ak = kpd_pkg::ANS_CHOICE;
                            res_av = v5;
                        end
                    end
                    kpd_pkg::MODE_MULTIPLE:
                    begin
                        if (v5 == 7'd0)
                        begin
                            res_ak = kpd_pkg::ANS_RUSH;
                        end
                        else
                        begin
                            res_ak = kpd_pkg::ANS_MASK;
                            res_av = {1'b0, v5[5:0]};
                        end
                    end
                    kpd_pkg::MODE_NUMBER, kpd_pkg::MODE_TEXT:
                    begin
                        if (v5 == kpd_pkg::NUMBER_RUSH)
                        begin
                            res_ak = kpd_pkg::ANS_RUSH;
                        end
                        else if (v5 <= kpd_pkg::NUMBER_MAX)
                        begin
                            res_ak = kpd_pkg::ANS_NUMBER;
                            res_av = v5;
                        end
                    end
                    default:
                    begin
                        res_ak = kpd_pkg::ANS_NONE;
                    end
                endcase
            end
            else if (top5 == kpd_pkg::TOP_SET_ID)
            begin
                res_valid = 1'b1;
                res_kind  = kpd_pkg::KIND_SET_ID;
            end
            else if (quiz_mode_reg == kpd_pkg::MODE_UNKNOWN)
            begin
                res_valid = 1'b1;
                res_kind  = kpd_pkg::KIND_UNCLASS;
            end
        end
    end

    // next window: cleared on a packet, else dropped from the oldest end
    always_comb
    begin
        shift      = 2'd0;
        count_next = app_count;
        if (hw_hit || five_hit)
        begin
            count_next = '0;
        end
        else if (hw_mode)
        begin
            if (hw_full)
            begin
                shift      = 2'd1;
                count_next = app_count - kpd_pkg::CNT_W'(1);
            end
        end
        else if (app_count >= kpd_pkg::CNT_W'(5))
        begin
            // every candidate failed: keep only the last four bytes
            shift      = 2'(app_count - kpd_pkg::CNT_W'(4));
            count_next = kpd_pkg::CNT_W'(4);
        end
        for (int i = 0; i < kpd_pkg::WIN_DEPTH; i++)
        begin
            case (shift)
                2'd0:    win_next[i] = app[i];
                2'd1:    win_next[i] = (i + 1 < kpd_pkg::WIN_DEPTH) ? app[i + 1] : app[i];
                2'd2:    win_next[i] = (i + 2 < kpd_pkg::WIN_DEPTH) ? app[i + 2] : app[i];
                default: win_next[i] = (i + 3 < kpd_pkg::WIN_DEPTH) ? app[i + 3] : app[i];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (in_accept)
        begin
            count_reg <= count_next;
        end
    end

    // window bytes carry no reset: only entries below the count are used
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            for (int i = 0; i < kpd_pkg::WIN_DEPTH; i++)
            begin
                win_reg[i] <= win_next[i];
            end
        end
    end

    // output register
    logic [1:0]        msg_kind_reg;
    logic [8:0]        keypad_id_reg;
    logic [7:0]        quiz_number_reg;
    logic [2:0]        answer_kind_reg;
    logic [6:0]        answer_value_reg;
    logic [23:0]       answer_codes_reg;
    logic [55:0]       packet_bytes_reg;
    logic [2:0]        packet_length_reg;
    logic              out_valid_next;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_accept)
        begin
            out_valid_next = res_valid;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && res_valid)
        begin
            msg_kind_reg      <= res_kind;
            keypad_id_reg     <= res_kp;
            quiz_number_reg   <= res_qn;
            answer_kind_reg   <= res_ak;
            answer_value_reg  <= res_av;
            answer_codes_reg  <= res_codes;
            packet_bytes_reg  <= res_bytes;
            packet_length_reg <= res_len;
        end
    end

    assign out_valid     = out_valid_reg;
    assign msg_kind      = msg_kind_reg;
    assign keypad_id     = keypad_id_reg;
    assign quiz_number   = $signed(quiz_number_reg);
    assign answer_kind   = answer_kind_reg;
    assign answer_value  = answer_value_reg;
    assign answer_codes  = answer_codes_reg;
    assign packet_bytes  = packet_bytes_reg;
    assign packet_length = packet_length_reg;

    // checks
    `include "keypad_packet_deframer_core_assert.svh"

    `KPD_ASSERT(a_five_count_bound, (in_accept && !hw_mode) |=> (count_reg <= 3'd4), "five-byte modes must leave at most four bytes")
    `KPD_ASSERT(a_hw_count_bound, (in_accept && hw_mode) |=> (count_reg <= 3'd6), "homework mode must not keep a full window")
    `KPD_ASSERT(a_result_clears, (in_accept && res_valid) |=> (count_reg == 3'd0), "a decoded packet must clear the window")
    `KPD_ASSERT_ALWAYS(a_long_is_homework, (out_valid && packet_length == kpd_pkg::LEN_LONG) |-> (answer_kind == kpd_pkg::ANS_HOMEWORK), "seven-byte result must carry homework codes")

endmodule
